### rtl/spq_pkg.sv
package spq_pkg;

	localparam int unsigned PRIO_W = 8;
	localparam int unsigned TAG_W  = 32;
	localparam int unsigned OCC_W  = 5;
	localparam int unsigned STAT_W = 2;

	// Stream payload widths, padded to whole bytes.
	localparam int unsigned IN_DATA_W  = 40;
	localparam int unsigned OUT_DATA_W = 48;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_POP    = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	// One stored entry; the priority sits in the low bits.
	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

### rtl/spq_ram.sv
module spq_ram #(
	parameter int unsigned WIDTH = 40,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/stable_priority_queue.sv
// Bounded, stable priority queue. Entries are kept in ascending order of
// priority number (lower is more urgent) in one synchronous RAM that is used
// as a ring: a head pointer marks the front entry and a tail pointer the first
// free slot. A pop issues the read at the head in S_IDLE, then returns the
// entry and advances the head in S_POP. An insert walks backward from the
// tail, moving each held entry of strictly higher priority number one slot
// toward the tail, one entry per cycle through the single RAM write port, and
// then drops the new entry into the gap. Equal priorities therefore leave in
// arrival order. Into an empty queue the new entry is written straight to the
// tail. A refused transaction (insert when full, pop when empty) leaves the
// state alone. Every input transaction yields exactly one result transaction;
// the result sits in an output register, and if that register is still
// occupied when a result is ready the block parks the result in a second
// register and accepts no new transaction until the output register frees up.
// No clearing pass is needed after reset because only slots between head and
// tail are read.
module stable_priority_queue
	import spq_pkg::*;
#(
	parameter int unsigned CAPACITY = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input stream.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // priority_req[7:0], tag[39:8]
	input  logic                  s_tuser,   // command[0]
	// Result stream.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // out_priority[7:0], out_tag[39:8],
	                                         // occupancy[44:40], zero[47:45]
	output logic [STAT_W-1:0]     m_tuser    // status[1:0]
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);
	localparam logic [CW-1:0] CAP_CNT   = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_CNT   = CW'(1);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_WALK  = 5'b00010,
		S_PLACE = 5'b00100,
		S_POP   = 5'b01000,
		S_RESP  = 5'b10000
	} state_t;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == LAST_ADDR) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
		return (p == '0) ? LAST_ADDR : p - 1'b1;
	endfunction

	state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] head_q, head_d;
	logic [AW-1:0] tail_q, tail_d;

	// Walk pointers: rd_q is the slot whose data arrives this cycle, wr_q the
	// slot just behind it, rem_q the number of held entries not yet compared.
	logic [AW-1:0] rd_q, rd_d;
	logic [AW-1:0] wr_q, wr_d;
	logic [CW-1:0] rem_q, rem_d;
	entry_t        ins_q, ins_d;

	// RAM port.
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	entry_t        ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	entry_t        ram_rdata;

	// Result of the transaction that finishes this cycle.
	logic              fin;
	logic [STAT_W-1:0] fin_status;
	entry_t            fin_entry;
	logic [OCC_W-1:0]  fin_occ;
	logic [CW+OCC_W-1:0] occ_ext;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [STAT_W-1:0]     out_user_q;
	logic [OUT_DATA_W-1:0] pend_data_q;
	logic [STAT_W-1:0]     pend_user_q;
	logic [OUT_DATA_W-1:0] fin_data;
	logic                  out_free;
	logic                  load_out;
	logic                  load_pend;

	entry_t in_entry;

	assign in_entry.prio = s_tdata[PRIO_W-1:0];
	assign in_entry.tag  = s_tdata[PRIO_W+TAG_W-1:PRIO_W];

	assign s_tready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || m_tready;

	spq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		head_d     = head_q;
		tail_d     = tail_q;
		rd_d       = rd_q;
		wr_d       = wr_q;
		rem_d      = rem_q;
		ins_d      = ins_q;
		ram_we     = 1'b0;
		ram_waddr  = wr_q;
		ram_wdata  = ins_q;
		ram_re     = 1'b0;
		ram_raddr  = head_q;
		fin        = 1'b0;
		fin_status = ST_OK;
		fin_entry  = '0;

		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser == CMD_INSERT) begin
						ins_d = in_entry;
						if (count_q == CAP_CNT) begin
							fin        = 1'b1;
							fin_status = ST_FULL;
						end else if (count_q == '0) begin
							// Empty queue: the entry goes straight to the tail.
							ram_we    = 1'b1;
							ram_waddr = tail_q;
							ram_wdata = in_entry;
							tail_d    = ptr_inc(tail_q);
							count_d   = count_q + 1'b1;
							fin       = 1'b1;
						end else begin
							ram_re    = 1'b1;
							ram_raddr = ptr_dec(tail_q);
							rd_d      = ptr_dec(tail_q);
							wr_d      = tail_q;
							rem_d     = count_q;
							state_d   = S_WALK;
						end
					end else begin
						if (count_q == '0) begin
							fin        = 1'b1;
							fin_status = ST_EMPTY;
						end else begin
							ram_re    = 1'b1;
							ram_raddr = head_q;
							state_d   = S_POP;
						end
					end
				end
			end
			S_WALK: begin
				if (ram_rdata.prio > ins_q.prio) begin
					// Move the held entry one slot toward the tail.
					ram_we    = 1'b1;
					ram_waddr = wr_q;
					ram_wdata = ram_rdata;
					wr_d      = rd_q;
					if (rem_q == ONE_CNT) begin
						state_d = S_PLACE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = ptr_dec(rd_q);
						rd_d      = ptr_dec(rd_q);
						rem_d     = rem_q - 1'b1;
					end
				end else begin
					// Held entry is no larger: the new one belongs right behind it.
					ram_we    = 1'b1;
					ram_waddr = wr_q;
					ram_wdata = ins_q;
					tail_d    = ptr_inc(tail_q);
					count_d   = count_q + 1'b1;
					fin       = 1'b1;
				end
			end
			S_PLACE: begin
				// Every held entry moved; the new entry becomes the front.
				ram_we    = 1'b1;
				ram_waddr = wr_q;
				ram_wdata = ins_q;
				tail_d    = ptr_inc(tail_q);
				count_d   = count_q + 1'b1;
				fin       = 1'b1;
			end
			S_POP: begin
				fin       = 1'b1;
				fin_entry = ram_rdata;
				head_d    = ptr_inc(head_q);
				count_d   = count_q - 1'b1;
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		load_out  = 1'b0;
		load_pend = 1'b0;
		if (fin) begin
			if (out_free) begin
				load_out = 1'b1;
				state_d  = S_IDLE;
			end else begin
				load_pend = 1'b1;
				state_d   = S_RESP;
			end
		end
	end

	// Occupancy is reported modulo 32.
	assign occ_ext  = (CW + OCC_W)'(count_d);
	assign fin_occ  = occ_ext[OCC_W-1:0];
	assign fin_data = {3'b000, fin_occ, fin_entry.tag, fin_entry.prio};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			if (load_out || (state_q == S_RESP && out_free)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_q  <= rd_d;
		wr_q  <= wr_d;
		rem_q <= rem_d;
		ins_q <= ins_d;
		if (load_out) begin
			out_data_q <= fin_data;
			out_user_q <= fin_status;
		end else if (state_q == S_RESP && out_free) begin
			out_data_q <= pend_data_q;
			out_user_q <= pend_user_q;
		end
		if (load_pend) begin
			pend_data_q <= fin_data;
			pend_user_q <= fin_status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
	import spq_pkg::*;

	localparam int unsigned QUEUE_DEPTH = 16;
	localparam int unsigned PAD_W       = OUT_DATA_W - TAG_W - PRIO_W - OCC_W;
	localparam int unsigned HOLD_CYCLES = 150;
	localparam int unsigned ROUNDS      = 10;
	localparam int unsigned TIMEOUT_NS  = 1_000_000;

	// One result transaction as seen on the result stream; status comes from tuser and
	// sits above the tdata fields so that {tuser, tdata} maps onto it directly.
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [PAD_W-1:0]  pad;
		logic [OCC_W-1:0]  occupancy;
		logic [TAG_W-1:0]  tag;
		logic [PRIO_W-1:0] prio;
	} queue_result_t;

	// Keeps a sorted copy of the queue contents and the results still owed by the block.
	class queue_scoreboard;
		entry_t        held_entries[$];
		queue_result_t awaited_results[$];
		int unsigned   errors;
		int unsigned   results_checked;
		int unsigned   inserts;
		int unsigned   pops;
		int unsigned   refused_full;
		int unsigned   refused_empty;
		int unsigned   deepest;

		// Applies one accepted request to the sorted copy and queues the result it owes.
		function void note_request(logic cmd, logic [PRIO_W-1:0] prio, logic [TAG_W-1:0] tag);
			queue_result_t owed;
			entry_t        fresh;
			int            pos;
			owed = '0;
			if (cmd == CMD_INSERT) begin
				inserts++;
				if (held_entries.size() >= QUEUE_DEPTH) begin
					owed.status = ST_FULL;
					refused_full++;
				end else begin
					// A new entry goes behind every held entry of lower or equal number.
					pos = 0;
					while (pos < held_entries.size() && held_entries[pos].prio <= prio)
						pos++;
					fresh.prio = prio;
					fresh.tag  = tag;
					held_entries.insert(pos, fresh);
					owed.status = ST_OK;
				end
			end else begin
				pops++;
				if (held_entries.size() == 0) begin
					owed.status = ST_EMPTY;
					refused_empty++;
				end else begin
					fresh       = held_entries.pop_front();
					owed.status = ST_OK;
					owed.prio   = fresh.prio;
					owed.tag    = fresh.tag;
				end
			end
			owed.occupancy = OCC_W'(held_entries.size());
			if (held_entries.size() > deepest)
				deepest = held_entries.size();
			awaited_results.push_back(owed);
		endfunction

		// Compares one accepted result transaction against the oldest owed result.
		function void check_result(logic [STAT_W-1:0] status, logic [OUT_DATA_W-1:0] data);
			queue_result_t got;
			queue_result_t owed;
			got = queue_result_t'({status, data});
			results_checked++;
			if (awaited_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("tb: unexpected result at %0t: status %0d prio %0d tag %h occ %0d",
						$realtime, got.status, got.prio, got.tag, got.occupancy);
				return;
			end
			owed = awaited_results.pop_front();
			if (got.status !== owed.status || got.prio !== owed.prio || got.tag !== owed.tag ||
					got.occupancy !== owed.occupancy || got.pad !== owed.pad) begin
				errors++;
				if (errors <= 10) begin
					$display("tb: mismatch on result %0d at %0t: expected status %0d prio %0d tag %h occ %0d pad %b",
						results_checked, $realtime, owed.status, owed.prio, owed.tag,
						owed.occupancy, owed.pad);
					$display("tb:   got status %0d prio %0d tag %h occ %0d pad %b",
						got.status, got.prio, got.tag, got.occupancy, got.pad);
				end
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;    // priority_req[7:0], tag[39:8]
	logic                  s_tuser;    // command[0]
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;    // out_priority[7:0], out_tag[39:8], occupancy[44:40]
	logic [STAT_W-1:0]     m_tuser;    // status[1:0]

	queue_scoreboard sb;
	bit              steady;        // both sides stop idling while this is set
	bit              hold_pending;  // asks the receiver for one long hold-off
	int unsigned     holds_done;
	int unsigned     input_stalls;
	int unsigned     requests_sent;

	stable_priority_queue #(.CAPACITY(QUEUE_DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	// Offers one request transaction; entered and left at a falling edge.
	task automatic send_request(logic cmd, logic [PRIO_W-1:0] prio, logic [TAG_W-1:0] tag);
		while (!steady && $urandom_range(0, 99) < 13) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {tag, prio};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_request(cmd, prio, tag);
		requests_sent++;
		@(negedge clk);
	endtask

	// Random requests with a given share of pops and a given priority range.
	task automatic run_burst(int unsigned count, int unsigned pop_pct,
			int unsigned prio_lo, int unsigned prio_hi);
		logic              cmd;
		logic [PRIO_W-1:0] prio;
		for (int i = 0; i < count; i++) begin
			cmd  = ($urandom_range(0, 99) < pop_pct) ? CMD_POP : CMD_INSERT;
			prio = PRIO_W'($urandom_range(prio_lo, prio_hi));
			send_request(cmd, prio, $urandom());
		end
	endtask

	// Result side: random back-pressure, plus one long hold-off whenever asked for.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				holds_done++;
				m_tready <= 1'b0;
				for (int c = 0; c < HOLD_CYCLES; c++)
					@(negedge clk);
			end
			m_tready <= steady || ($urandom_range(0, 99) >= 13);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata);
		if (arst_n && s_tvalid && !s_tready)
			input_stalls++;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("tb: timed out with %0d results still owed", sb.awaited_results.size());
		$display("tb: FAIL");
		$finish;
	end

	initial begin
		sb       = new();
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tuser  = CMD_INSERT;
		s_tdata  = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: pop on an empty queue, priority and tag extremes, ties at the
		// front, middle and back, a full queue, then a refused insert of the lowest
		// priority number, and a few pops to read back the order.
		send_request(CMD_POP, 8'hAA, 32'h5A5A_A5A5);
		send_request(CMD_INSERT, 8'd255, 32'hFFFF_FFFF);
		send_request(CMD_INSERT, 8'd0, 32'h0000_0000);
		send_request(CMD_INSERT, 8'd128, 32'h0000_0A01);
		send_request(CMD_INSERT, 8'd128, 32'h0000_0A02);
		send_request(CMD_INSERT, 8'd0, 32'h0000_0B01);
		send_request(CMD_INSERT, 8'd255, 32'h0000_0C01);
		for (int i = 0; i < QUEUE_DEPTH - 6; i++)
			send_request(CMD_INSERT, PRIO_W'(i * 37), 32'h1000_0000 + i);
		send_request(CMD_INSERT, 8'd0, 32'hDEAD_BEEF);
		for (int i = 0; i < 5; i++)
			send_request(CMD_POP, PRIO_W'(i), 32'hFFFF_FFFF);

		// Random part: each round fills, churns on a narrow band of priorities so that
		// ties are common, then drains past empty. One round runs without any idling,
		// and two rounds open with a long hold-off on the result side.
		for (int r = 0; r < ROUNDS; r++) begin
			if (r == 2 || r == 7)
				hold_pending = 1'b1;
			if (r == 4)
				steady = 1'b1;
			run_burst(40, 20, 0, 255);
			if (r % 2 == 1)
				run_burst(40, 45, 252, 255);
			else
				run_burst(40, 45, 0, 3);
			run_burst(45, 75, 0, 255);
			steady = 1'b0;
		end
		s_tvalid <= 1'b0;

		while (sb.awaited_results.size() != 0)
			@(posedge clk);
		// Longest insert shifts the whole store; leave room for any stray result.
		repeat (2 * QUEUE_DEPTH + 8) @(posedge clk);

		$display("tb: %0d requests (%0d inserts, %0d pops), %0d results checked, %0d errors",
			requests_sent, sb.inserts, sb.pops, sb.results_checked, sb.errors);
		$display("tb: %0d refused full, %0d refused empty, deepest %0d, %0d hold-offs, %0d stalls",
			sb.refused_full, sb.refused_empty, sb.deepest, holds_done, input_stalls);
		if (sb.errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

### files.f
rtl/spq_pkg.sv
rtl/spq_ram.sv
rtl/stable_priority_queue.sv
sim/tb.sv
